// ----- rtl/ppt_pkg.sv -----
// Shared types and constants for the point-in-polygon test block.
// Used by ppt_cell, ppt_edge and point_in_polygon_test_top; no dependencies.

package ppt_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_W      = 32;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int PROD_W       = 2 * DIFF_W;
  localparam int IDX_W        = 6;
  localparam int VC_W         = 7;
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int CMP_W        = (CNT_W > VC_W) ? CNT_W : VC_W;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_TEST  = 1'b1;

  typedef struct packed {
    logic [COORD_W-1:0] lat;
    logic [COORD_W-1:0] lon;
  } vertex_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic run;
    logic start;
    logic edge_vld;
    logic use_first;
    logic last;
  } step_t;

endpackage

// ----- rtl/ppt_cell.sv -----
// One vertex cell of the rotating vertex ring.
// Depends on ppt_pkg for vertex_t and cell_ctrl_t.

module ppt_cell
  import ppt_pkg::*;
(
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  vertex_t    wr_data_i,
  input  vertex_t    nb_data_i,
  output vertex_t    vtx_o
);

  vertex_t vtx_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      vtx_q <= wr_data_i;
    end else if (ctrl_i.shift) begin
      vtx_q <= nb_data_i;
    end
  end

  assign vtx_o = vtx_q;

endmodule

// ----- rtl/ppt_edge.sv -----
// Edge crossing unit: three-stage pipeline (differences, products, compare/toggle).
// Depends on ppt_pkg for vertex_t, step_t and widths.

module ppt_edge
  import ppt_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  step_t                     step_i,
  input  vertex_t                   head_i,
  input  logic signed [COORD_W-1:0] pt_lon_i,
  input  logic signed [COORD_W-1:0] pt_lat_i,
  output logic                      done_o,
  output logic                      inside_o
);

  vertex_t prev_q;
  vertex_t first_q;
  vertex_t cur;

  logic signed [COORD_W-1:0] xi, yi, xj, yj;
  logic                      cond;

  logic                     vld1_q, last1_q;
  logic signed [DIFF_W-1:0] a1_q, b1_q, c1_q, d1_q;

  logic                     vld2_q, last2_q, dpos2_q;
  logic signed [PROD_W-1:0] lhs2_q, rhs2_q;

  logic flag_q, done_q;
  logic hit;

  always_ff @(posedge clk_i) begin
    if (step_i.run) begin
      prev_q <= head_i;
    end
    if (step_i.start) begin
      first_q <= head_i;
    end
  end

  assign cur  = step_i.use_first ? first_q : head_i;
  assign xi   = $signed(cur.lon);
  assign yi   = $signed(cur.lat);
  assign xj   = $signed(prev_q.lon);
  assign yj   = $signed(prev_q.lat);
  assign cond = (yi > pt_lat_i) != (yj > pt_lat_i);

  // stage 1: operand differences
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q  <= 1'b0;
      last1_q <= 1'b0;
    end else begin
      vld1_q  <= step_i.edge_vld && cond;
      last1_q <= step_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q <= DIFF_W'(pt_lon_i) - DIFF_W'(xi);
    b1_q <= DIFF_W'(yj) - DIFF_W'(yi);
    c1_q <= DIFF_W'(xj) - DIFF_W'(xi);
    d1_q <= DIFF_W'(pt_lat_i) - DIFF_W'(yi);
  end

  // stage 2: cross products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q  <= 1'b0;
      last2_q <= 1'b0;
    end else begin
      vld2_q  <= vld1_q;
      last2_q <= last1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    lhs2_q  <= PROD_W'(a1_q) * PROD_W'(b1_q);
    rhs2_q  <= PROD_W'(c1_q) * PROD_W'(d1_q);
    dpos2_q <= b1_q > 0;
  end

  // stage 3: compare, sense flipped by sign of dlat
  assign hit = dpos2_q ? (lhs2_q < rhs2_q) : (rhs2_q < lhs2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= last2_q;
      if (step_i.start) begin
        flag_q <= 1'b0;
      end else if (vld2_q && hit) begin
        flag_q <= !flag_q;
      end
    end
  end

  assign done_o   = done_q;
  assign inside_o = flag_q;

endmodule

// ----- rtl/point_in_polygon_test_top.sv -----
// Point-in-polygon test by even-odd ray casting over a rotating ring of vertex cells.
// Depends on ppt_pkg, ppt_cell and ppt_edge.
//
//  channel | signals                                  | transaction when
//  --------+------------------------------------------+-------------------------
//  input   | in_valid_i/in_stall_o + request fields   | valid high, stall low
//  output  | out_valid_o/out_stall_i + inside_res_o   | valid high, stall low
//  config  | cfg_valid_i/cfg_ready_o + cfg_data_i     | valid and ready high
//
// A test rotates the ring once, one vertex per cycle into the edge unit: MAX_VERTICES + 1
// steps, then the edge-unit pipeline (differences, products, compare/toggle).
// The ring returns to its home position at the end of every test.
// Reset clears control and vertex_count; vertex cells are not reset.
// A result held by out_stall_i blocks the next test from finishing, not from starting.

module point_in_polygon_test_top
  import ppt_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      req_type_i,
  input  logic [IDX_W-1:0]          vertex_index_i,
  input  logic signed [COORD_W-1:0] coord_lon_i,
  input  logic signed [COORD_W-1:0] coord_lat_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      inside_res_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [VC_W-1:0]           cfg_data_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] step_q, step_d;
  logic [VC_W-1:0]  vcount_q;
  logic [CNT_W-1:0] n_eff;

  logic signed [COORD_W-1:0] pt_lon_q, pt_lat_q;
  logic                      out_valid_q, out_valid_d;
  logic                      out_q, out_d;

  logic in_acc, wr_acc, test_acc, out_free, running;
  step_t   step;
  vertex_t wr_vtx;
  vertex_t ring [MAX_VERTICES];
  logic    done, in_poly;

  assign in_stall_o  = state_q != ST_IDLE;
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign wr_acc      = in_acc && (req_type_i == REQ_WRITE);
  assign test_acc    = in_acc && (req_type_i == REQ_TEST);
  assign running     = state_q == ST_RUN;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    if (CMP_W'(vcount_q) > CMP_W'(MAX_VERTICES)) begin
      n_eff = CNT_W'(MAX_VERTICES);
    end else begin
      n_eff = CNT_W'(vcount_q);
    end
  end

  assign wr_vtx.lon = coord_lon_i;
  assign wr_vtx.lat = coord_lat_i;

  assign step.run       = running && (step_q != CNT_W'(MAX_VERTICES) + CNT_W'(1));
  assign step.start     = step.run && (step_q == '0);
  assign step.edge_vld  = step.run && (step_q != '0) && (step_q <= n_eff);
  assign step.use_first = step_q == n_eff;
  assign step.last      = step.run && (step_q == CNT_W'(MAX_VERTICES));

  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
    cell_ctrl_t ctrl;
    assign ctrl.load  = wr_acc && (k < (1 << IDX_W)) && (vertex_index_i == IDX_W'(k));
    assign ctrl.shift = step.run && (step_q < CNT_W'(MAX_VERTICES));
    ppt_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .wr_data_i (wr_vtx),
      .nb_data_i (ring[(k + 1) % MAX_VERTICES]),
      .vtx_o     (ring[k])
    );
  end

  ppt_edge u_edge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .head_i   (ring[0]),
    .pt_lon_i (pt_lon_q),
    .pt_lat_i (pt_lat_q),
    .done_o   (done),
    .inside_o (in_poly)
  );

  always_ff @(posedge clk_i) begin
    if (test_acc) begin
      pt_lon_q <= coord_lon_i;
      pt_lat_q <= coord_lat_i;
    end
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    unique case (state_q)
      ST_IDLE: begin
        if (test_acc) begin
          state_d = ST_RUN;
          step_d  = '0;
        end
      end
      ST_RUN: begin
        if (step.run) begin
          step_d = step_q + CNT_W'(1);
        end
        if (done) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_d       = in_poly;
            state_d     = ST_IDLE;
          end else begin
            state_d = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = in_poly;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      vcount_q    <= '0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        vcount_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o  = out_valid_q;
  assign inside_res_o = out_q;

endmodule
